// File: rtl/ppd_pkg.sv
// Shared types, constants and codes for the pixel point dedup block.
package ppd_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int COORD_W   = 16;
  localparam int CFG_W     = 12;
  localparam int EDGE_W    = CFG_W + 1;
  localparam int TAG_W     = 32;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int MAP_BITS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W     = $clog2(MAP_BITS);
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = IDX_W - BIT_W;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int EPOCH_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0]  SWEEP_LAST = ADDR_W'(MAP_WORDS - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  typedef enum logic {
    OP_POINT     = 1'b0,
    OP_NEW_FRAME = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT   = 2'd0,
    REG_RECT_RIGHT  = 2'd1,
    REG_RECT_TOP    = 2'd2,
    REG_RECT_BOTTOM = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    SWEEP = 1'b0,
    RUN   = 1'b1
  } sweep_state_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [COORD_W-1:0] key_pixel;
    logic signed [COORD_W-1:0] value_pixel;
    logic [TAG_W-1:0]          point_tag;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_key_pixel;
    logic signed [COORD_W-1:0] out_value_pixel;
    logic [TAG_W-1:0]          out_tag;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] rect_left;
    logic [CFG_W-1:0] rect_right;
    logic [CFG_W-1:0] rect_top;
    logic [CFG_W-1:0] rect_bottom;
  } rect_cfg_t;

  // One map word: the epoch it was written in and 32 visited bits.
  typedef struct packed {
    logic [EPOCH_W-1:0]   epoch;
    logic [WORD_BITS-1:0] bits;
  } map_word_t;

  // Item after the address stage, on its way to the mark stage.
  typedef struct packed {
    logic                      valid;
    op_e                       operation;
    logic                      wrap;
    logic                      keep;
    logic [ADDR_W-1:0]         addr;
    logic [BIT_W-1:0]          bitsel;
    logic signed [COORD_W-1:0] key_pixel;
    logic signed [COORD_W-1:0] value_pixel;
    logic [TAG_W-1:0]          point_tag;
  } lookup_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    map_word_t         data;
  } mem_wr_t;

  typedef struct packed {
    logic sweeping;
    logic sweep_done;
    logic item_write;
  } mark_status_t;

endpackage

// File: rtl/pixel_point_dedup_unit.sv
// Top level of the pixel point dedup block: ports, config, output register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------
//  in       | in_valid / in_stall | in_data  (operation, key, value, tag)
//  out      | out_valid/out_stall | out_data (key, value, tag)
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// One item per cycle unless a stalled output, a pending epoch wrap or the clearing sweep holds
// the input; a kept point passes the input register, the address stage, the map read and the output register.
// The visited map is one 8192 x 40 RAM with registered read; back-to-back hits
// on the same word are served from the last write.
// After reset the RAM is swept clear before the first item is taken;
// the same sweep follows every 256th new frame.
// A stalled output freezes the whole pipeline, input included.
module pixel_point_dedup_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ppd_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppd_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [ppd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppd_pkg::CFG_W-1:0]     cfg_data
);

  ppd_pkg::rect_cfg_t    cfg;
  ppd_pkg::lookup_t      lookup;
  ppd_pkg::map_word_t    rdata;
  ppd_pkg::mem_wr_t      wr;
  ppd_pkg::out_item_t    emit_item;
  ppd_pkg::mark_status_t status;

  logic                        adv;
  logic                        take;
  logic                        take_wrap;
  logic                        emit;
  logic                        wrap_pending;
  logic [ppd_pkg::EPOCH_W-1:0] in_epoch;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rect_left   <= ppd_pkg::CFG_W'(0);
      cfg.rect_right  <= ppd_pkg::CFG_W'(511);
      cfg.rect_top    <= ppd_pkg::CFG_W'(0);
      cfg.rect_bottom <= ppd_pkg::CFG_W'(511);
    end else if (cfg_we) begin
      case (ppd_pkg::cfg_reg_e'(cfg_index))
        ppd_pkg::REG_RECT_LEFT:   cfg.rect_left   <= cfg_data;
        ppd_pkg::REG_RECT_RIGHT:  cfg.rect_right  <= cfg_data;
        ppd_pkg::REG_RECT_TOP:    cfg.rect_top    <= cfg_data;
        ppd_pkg::REG_RECT_BOTTOM: cfg.rect_bottom <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv || status.sweeping || wrap_pending;
  assign take      = in_valid && !in_stall;
  assign take_wrap = (in_data.operation == ppd_pkg::OP_NEW_FRAME) &&
                     (in_epoch == ppd_pkg::EPOCH_LAST);

  // track the epoch at the input; hold input from a wrapping frame to sweep end
  always_ff @(posedge clk) begin
    if (rst) begin
      in_epoch     <= '0;
      wrap_pending <= 1'b0;
    end else begin
      if (take && (in_data.operation == ppd_pkg::OP_NEW_FRAME)) begin
        in_epoch <= in_epoch + 1'b1;
      end
      if (take && take_wrap) begin
        wrap_pending <= 1'b1;
      end else if (status.sweep_done) begin
        wrap_pending <= 1'b0;
      end
    end
  end

  ppd_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .take      (take),
    .take_wrap (take_wrap),
    .in_data   (in_data),
    .cfg       (cfg),
    .lookup    (lookup)
  );

  ppd_map_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .re    (adv),
    .raddr (lookup.addr),
    .rdata (rdata)
  );

  ppd_mark u_mark (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .lookup    (lookup),
    .rdata     (rdata),
    .wr        (wr),
    .emit      (emit),
    .emit_item (emit_item),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data <= emit_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    status.sweeping |-> !status.item_write)
    else $error("item write to the map during the clearing sweep");

  a_sweep_ends_clean: assert property (@(posedge clk) disable iff (rst)
    status.sweep_done |=> !status.sweeping)
    else $error("clearing sweep restarted right after finishing");

  a_out_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(status.item_write))
    else $error("result emitted without marking the map");

  a_wrap_holds_input: assert property (@(posedge clk) disable iff (rst)
    (take && take_wrap) |=> in_stall)
    else $error("input taken behind an epoch-wrapping new frame");
`endif

endmodule

// File: rtl/ppd_map_ram.sv
// Visited map storage: one write port, one read port with registered data.
module ppd_map_ram (
  input  logic                      clk,
  input  ppd_pkg::mem_wr_t          wr,
  input  logic                      re,
  input  logic [ppd_pkg::ADDR_W-1:0] raddr,
  output ppd_pkg::map_word_t        rdata
);

  ppd_pkg::map_word_t mem [ppd_pkg::MAP_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ppd_locate.sv
// Rectangle clipping, range check and map address of each item (two stages).
module ppd_locate (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              take,
  input  logic              take_wrap,
  input  ppd_pkg::in_item_t in_data,
  input  ppd_pkg::rect_cfg_t cfg,
  output ppd_pkg::lookup_t  lookup
);

  // stage A: registered input item
  logic              a_valid;
  logic              a_wrap;
  ppd_pkg::in_item_t a_item;

  // stage B: range result and offsets
  logic                          b_valid;
  logic                          b_wrap;
  logic                          b_keep;
  ppd_pkg::op_e                  b_op;
  logic [ppd_pkg::COL_W-1:0]     b_dx;
  logic [ppd_pkg::ROW_W-1:0]     b_dy;
  logic signed [ppd_pkg::COORD_W-1:0] b_key;
  logic signed [ppd_pkg::COORD_W-1:0] b_val;
  logic [ppd_pkg::TAG_W-1:0]     b_tag;

  logic [ppd_pkg::COORD_W-1:0] ku;
  logic [ppd_pkg::COORD_W-1:0] vu;
  logic [ppd_pkg::COORD_W-1:0] l16;
  logic [ppd_pkg::COORD_W-1:0] t16;
  logic [ppd_pkg::EDGE_W-1:0]  r_lim;
  logic [ppd_pkg::EDGE_W-1:0]  b_lim;
  logic [ppd_pkg::EDGE_W-1:0]  r_eff;
  logic [ppd_pkg::EDGE_W-1:0]  b_eff;
  logic                        keep;
  logic [ppd_pkg::COORD_W-1:0] dx_full;
  logic [ppd_pkg::COORD_W-1:0] dy_full;
  logic [ppd_pkg::IDX_W-1:0]   idx;

  localparam logic [ppd_pkg::IDX_W-1:0] WIDTH_K = ppd_pkg::IDX_W'(ppd_pkg::MAX_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_wrap <= take_wrap;
      a_item <= in_data;
    end
  end

  always_comb begin
    ku    = a_item.key_pixel;
    vu    = a_item.value_pixel;
    l16   = ppd_pkg::COORD_W'(cfg.rect_left);
    t16   = ppd_pkg::COORD_W'(cfg.rect_top);
    // clip the far edges to the map size
    r_lim = ppd_pkg::EDGE_W'(cfg.rect_left) + ppd_pkg::EDGE_W'(ppd_pkg::MAX_WIDTH - 1);
    b_lim = ppd_pkg::EDGE_W'(cfg.rect_top) + ppd_pkg::EDGE_W'(ppd_pkg::MAX_HEIGHT - 1);
    r_eff = (ppd_pkg::EDGE_W'(cfg.rect_right) < r_lim) ?
            ppd_pkg::EDGE_W'(cfg.rect_right) : r_lim;
    b_eff = (ppd_pkg::EDGE_W'(cfg.rect_bottom) < b_lim) ?
            ppd_pkg::EDGE_W'(cfg.rect_bottom) : b_lim;
    // negative coordinates fall outside; an inverted rectangle keeps nothing
    keep  = !ku[ppd_pkg::COORD_W-1] && !vu[ppd_pkg::COORD_W-1] &&
            (ku >= l16) && (ku <= ppd_pkg::COORD_W'(r_eff)) &&
            (vu >= t16) && (vu <= ppd_pkg::COORD_W'(b_eff));
    dx_full = ku - l16;
    dy_full = vu - t16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_wrap <= a_wrap;
      b_keep <= keep;
      b_op   <= a_item.operation;
      b_dx   <= dx_full[ppd_pkg::COL_W-1:0];
      b_dy   <= dy_full[ppd_pkg::ROW_W-1:0];
      b_key  <= a_item.key_pixel;
      b_val  <= a_item.value_pixel;
      b_tag  <= a_item.point_tag;
    end
  end

  always_comb begin
    idx = ppd_pkg::IDX_W'(b_dx) + ppd_pkg::IDX_W'(b_dy) * WIDTH_K;
    lookup.valid       = b_valid;
    lookup.operation   = b_op;
    lookup.wrap        = b_wrap;
    lookup.keep        = b_keep;
    lookup.addr        = idx[ppd_pkg::IDX_W-1:ppd_pkg::BIT_W];
    lookup.bitsel      = idx[ppd_pkg::BIT_W-1:0];
    lookup.key_pixel   = b_key;
    lookup.value_pixel = b_val;
    lookup.point_tag   = b_tag;
  end

endmodule

// File: rtl/ppd_mark.sv
// Visited-bit test and set with forwarding, frame epochs and the clearing sweep.
module ppd_mark (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  ppd_pkg::lookup_t      lookup,
  input  ppd_pkg::map_word_t    rdata,
  output ppd_pkg::mem_wr_t      wr,
  output logic                  emit,
  output ppd_pkg::out_item_t    emit_item,
  output ppd_pkg::mark_status_t status
);

  ppd_pkg::sweep_state_e state;
  ppd_pkg::sweep_state_e state_next;
  logic [ppd_pkg::ADDR_W-1:0]  sweep_addr;
  logic [ppd_pkg::ADDR_W-1:0]  sweep_addr_next;
  logic [ppd_pkg::EPOCH_W-1:0] epoch;

  logic              c_valid;
  ppd_pkg::lookup_t  c;

  logic                       fwd_valid;
  logic [ppd_pkg::ADDR_W-1:0] fwd_addr;
  ppd_pkg::map_word_t         fwd_word;

  ppd_pkg::map_word_t            cur;
  logic [ppd_pkg::WORD_BITS-1:0] live_bits;
  logic                          seen;
  logic                          hit;
  logic                          item_write;
  logic                          frame_done;
  ppd_pkg::map_word_t            new_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= lookup.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c <= lookup;
    end
  end

  always_comb begin
    // the read issued at the last advance missed the write made at that edge
    cur        = (fwd_valid && (fwd_addr == c.addr)) ? fwd_word : rdata;
    live_bits  = (cur.epoch == epoch) ? cur.bits : '0;
    seen       = live_bits[c.bitsel];
    hit        = c_valid && (c.operation == ppd_pkg::OP_POINT) && c.keep && !seen;
    item_write = adv && hit;
    frame_done = adv && c_valid && (c.operation == ppd_pkg::OP_NEW_FRAME);
    new_word.epoch = epoch;
    new_word.bits  = live_bits | (ppd_pkg::WORD_BITS'(1) << c.bitsel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (state == ppd_pkg::SWEEP) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= item_write;
    end
  end

  always_ff @(posedge clk) begin
    if (item_write) begin
      fwd_addr <= c.addr;
      fwd_word <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= '0;
    end else if (frame_done) begin
      epoch <= epoch + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ppd_pkg::SWEEP;
      sweep_addr <= '0;
    end else begin
      state      <= state_next;
      sweep_addr <= sweep_addr_next;
    end
  end

  always_comb begin
    state_next      = state;
    sweep_addr_next = sweep_addr;
    status.sweeping   = 1'b0;
    status.sweep_done = 1'b0;
    status.item_write = item_write;
    case (state)
      ppd_pkg::SWEEP: begin
        status.sweeping = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == ppd_pkg::SWEEP_LAST) begin
          status.sweep_done = 1'b1;
          state_next        = ppd_pkg::RUN;
          sweep_addr_next   = '0;
        end
      end
      ppd_pkg::RUN: begin
        // epoch wraps here: stale marks would come back to life, so wipe
        if (frame_done && c.wrap) begin
          state_next      = ppd_pkg::SWEEP;
          sweep_addr_next = '0;
        end
      end
      default: begin
        state_next      = ppd_pkg::SWEEP;
        sweep_addr_next = '0;
      end
    endcase
  end

  always_comb begin
    if (status.sweeping) begin
      wr.we   = 1'b1;
      wr.addr = sweep_addr;
      wr.data = '0;
    end else begin
      wr.we   = item_write;
      wr.addr = c.addr;
      wr.data = new_word;
    end
    emit = hit;
    emit_item.out_key_pixel   = c.key_pixel;
    emit_item.out_value_pixel = c.value_pixel;
    emit_item.out_tag         = c.point_tag;
  end

endmodule

// File: tb/pixel_point_dedup_checker.sv
// Checker for the pixel point dedup block: watches all ports, predicts and compares results.
module pixel_point_dedup_checker
  import ppd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   kept_pending,
  output int                   points_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LINES = 30;

  logic [CFG_W-1:0] left_edge;
  logic [CFG_W-1:0] right_edge;
  logic [CFG_W-1:0] top_edge;
  logic [CFG_W-1:0] bottom_edge;
  bit               visited [int];
  out_item_t        expected_kept [$];
  int               error_total = 0;
  int               checked_total = 0;

  task automatic report_mismatch(input string msg);
    if (error_total < REPORT_LINES) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_total++;
  endtask

  // Return 1 and the kept point when the point lands on a fresh pixel; mark it.
  function automatic bit mark_pixel(input in_item_t pt, output out_item_t kept);
    int k, v, l, r, t, b, idx;
    k = pt.key_pixel;
    v = pt.value_pixel;
    l = left_edge;
    r = right_edge;
    t = top_edge;
    b = bottom_edge;
    kept = '0;
    // Clip the rectangle to the map size.
    if (r > l + MAX_WIDTH - 1) r = l + MAX_WIDTH - 1;
    if (b > t + MAX_HEIGHT - 1) b = t + MAX_HEIGHT - 1;
    if (k < l || k > r || v < t || v > b) return 1'b0;
    idx = (k - l) + (v - t) * MAX_WIDTH;
    if (visited.exists(idx)) return 1'b0;
    visited[idx] = 1'b1;
    kept.out_key_pixel   = pt.key_pixel;
    kept.out_value_pixel = pt.value_pixel;
    kept.out_tag         = pt.point_tag;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (rst) begin
      left_edge   = '0;
      right_edge  = CFG_W'(511);
      top_edge    = '0;
      bottom_edge = CFG_W'(511);
      visited.delete();
      expected_kept.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_kept.size() == 0) begin
          report_mismatch($sformatf("unexpected point key %0d value %0d tag %h",
                                    out_data.out_key_pixel, out_data.out_value_pixel,
                                    out_data.out_tag));
        end else begin
          want = expected_kept.pop_front();
          checked_total++;
          if (out_data.out_key_pixel !== want.out_key_pixel)
            report_mismatch($sformatf("key pixel %0d, expected %0d",
                                      out_data.out_key_pixel, want.out_key_pixel));
          if (out_data.out_value_pixel !== want.out_value_pixel)
            report_mismatch($sformatf("value pixel %0d, expected %0d",
                                      out_data.out_value_pixel, want.out_value_pixel));
          if (out_data.out_tag !== want.out_tag)
            report_mismatch($sformatf("tag %h, expected %h", out_data.out_tag,
                                      want.out_tag));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_NEW_FRAME) begin
          visited.delete();
        end else if (mark_pixel(in_data, fresh)) begin
          expected_kept.push_back(fresh);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RECT_LEFT:   left_edge   = cfg_data;
          REG_RECT_RIGHT:  right_edge  = cfg_data;
          REG_RECT_TOP:    top_edge    = cfg_data;
          REG_RECT_BOTTOM: bottom_edge = cfg_data;
          default: ;
        endcase
      end
    end
    mismatches     <= error_total;
    kept_pending   <= expected_kept.size();
    points_checked <= checked_total;
  end

endmodule

// File: tb/pixel_point_dedup_unit_tb.sv
// Testbench top for the pixel point dedup block: clock, reset, stimulus and verdict.
module pixel_point_dedup_unit_tb;
  import ppd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CLK_PERIOD   = 10;
  localparam int  RESET_CYCLES = 12;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  DRAIN_GAP    = 12;
  localparam int  PHASE_ITEMS  = 60;
  localparam int  STORM_FRAMES = 270;
  // Longest quiet stretch is a full map sweep; allow several of those.
  localparam int  WATCHDOG_MAX = 40000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RECT_LEFT;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int mismatches;
  int kept_pending;
  int points_checked;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  int cur_left   = 0;
  int cur_right  = 511;
  int cur_top    = 0;
  int cur_bottom = 511;
  int clus_x     = 0;
  int clus_y     = 0;

  int items_sent    = 0;
  int frames_sent   = 0;
  int rect_settings = 0;

  pixel_point_dedup_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pixel_point_dedup_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .kept_pending   (kept_pending),
    .points_checked (points_checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Output side: a requested hold-off wins over random stalls.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("timeout after %0d cycles without a handshake", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t point_at(input int x, input int y, input logic [TAG_W-1:0] tag);
    in_item_t pt;
    pt.operation   = OP_POINT;
    pt.key_pixel   = COORD_W'(x);
    pt.value_pixel = COORD_W'(y);
    pt.point_tag   = tag;
    return pt;
  endfunction

  // New frame with junk coordinates and tag, which must be ignored.
  function automatic in_item_t frame_item();
    in_item_t fr;
    fr = in_item_t'({1'b0, $urandom(), $urandom()});
    fr.operation = OP_NEW_FRAME;
    return fr;
  endfunction

  function automatic int pick_edge(input int lo, input int hi);
    case ($urandom_range(3))
      0: return lo - 1;
      1: return lo;
      2: return hi;
      default: return hi + 1;
    endcase
  endfunction

  function automatic in_item_t random_item();
    int l, r, t, b, sel, x, y, span_x, span_y;
    l = cur_left;
    t = cur_top;
    r = (cur_right > l + MAX_WIDTH - 1) ? l + MAX_WIDTH - 1 : cur_right;
    b = (cur_bottom > t + MAX_HEIGHT - 1) ? t + MAX_HEIGHT - 1 : cur_bottom;
    span_x = (r - l > 11) ? 11 : ((r >= l) ? r - l : 2);
    span_y = (b - t > 11) ? 11 : ((b >= t) ? b - t : 2);
    sel = $urandom_range(99);
    if (sel < 3) return frame_item();
    if (sel < 75) begin
      // Dense cluster: many repeats and same-word neighbors.
      x = clus_x + $urandom_range(span_x);
      y = clus_y + $urandom_range(span_y);
    end else if (sel < 90) begin
      x = pick_edge(l, r);
      y = pick_edge(t, b);
    end else begin
      x = $urandom_range(16'hFFFF);
      y = $urandom_range(16'hFFFF);
    end
    return point_at(x, y, $urandom());
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data  = in_item_t'({1'($urandom()), $urandom(), $urandom()});
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    items_sent++;
    if (it.operation == OP_NEW_FRAME) frames_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Wait for every kept point, then let dropped items leave the pipeline.
  task automatic drain_all();
    int saved_pct;
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (kept_pending != 0 || hold_left != 0) @(posedge clk);
    saved_pct     = recv_idle_pct;
    recv_idle_pct = 0;
    repeat (DRAIN_GAP) @(posedge clk);
    recv_idle_pct = saved_pct;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_W'(v);
  endtask

  task automatic set_rect(input int l, input int r, input int t, input int b);
    write_reg(REG_RECT_LEFT, l);
    write_reg(REG_RECT_RIGHT, r);
    write_reg(REG_RECT_TOP, t);
    write_reg(REG_RECT_BOTTOM, b);
    @(negedge clk);
    cfg_we     = 1'b0;
    cur_left   = l;
    cur_right  = r;
    cur_top    = t;
    cur_bottom = b;
    rect_settings++;
  endtask

  task automatic random_rect();
    int sel, l, r, t, b;
    sel = $urandom_range(99);
    if (sel < 20) begin
      l = $urandom_range(4095);
      r = $urandom_range(4095);
      t = $urandom_range(4095);
      b = $urandom_range(4095);
    end else if (sel < 60) begin
      l = $urandom_range(4055);
      r = l + $urandom_range(40);
      t = $urandom_range(4055);
      b = t + $urandom_range(40);
    end else if (sel < 85) begin
      l = $urandom_range(300);
      r = 4095;
      t = $urandom_range(300);
      b = $urandom_range(4095, 1000);
    end else begin
      l = $urandom_range(1) ? 4095 : 0;
      r = $urandom_range(1) ? 4095 : 0;
      t = $urandom_range(1) ? 4095 : 0;
      b = $urandom_range(1) ? 4095 : 0;
    end
    set_rect(l, r, t, b);
  endtask

  task automatic run_phase(input int count);
    int r, b;
    r = (cur_right > cur_left + MAX_WIDTH - 1) ? cur_left + MAX_WIDTH - 1 : cur_right;
    b = (cur_bottom > cur_top + MAX_HEIGHT - 1) ? cur_top + MAX_HEIGHT - 1 : cur_bottom;
    clus_x = cur_left + ((r - cur_left > 11) ? $urandom_range(r - cur_left - 11) : 0);
    clus_y = cur_top + ((b - cur_top > 11) ? $urandom_range(b - cur_top - 11) : 0);
    repeat (count) send_item(random_item());
    drain_all();
  endtask

  // Push the frame count past the epoch wrap; stale marks must not survive it.
  task automatic frame_storm();
    send_item(point_at(cur_left + 3, cur_top + 3, $urandom()));
    send_item(point_at(cur_left + 40, cur_top + 7, $urandom()));
    for (int i = 0; i < STORM_FRAMES; i++) begin
      send_item(frame_item());
      if (i % 25 == 0) send_item(point_at(cur_left + 100, cur_top + i % 7, $urandom()));
    end
    send_item(point_at(cur_left + 3, cur_top + 3, $urandom()));
    send_item(point_at(cur_left + 3, cur_top + 3, $urandom()));
    send_item(point_at(cur_left + 40, cur_top + 7, $urandom()));
    drain_all();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: default 512 x 512 rectangle.
    send_item(point_at(0, 0, 32'h0000_0000));
    send_item(point_at(0, 0, 32'hFFFF_FFFF));
    send_item(point_at(511, 511, $urandom()));
    send_item(point_at(512, 511, $urandom()));
    send_item(point_at(511, 512, $urandom()));
    send_item(point_at(-1, 0, $urandom()));
    send_item(point_at(0, -1, $urandom()));
    send_item(point_at(-32768, -32768, $urandom()));
    send_item(point_at(32767, 32767, $urandom()));
    send_item(point_at(1, 0, $urandom()));
    send_item(point_at(2, 0, $urandom()));
    send_item(point_at(1, 0, $urandom()));
    send_item(frame_item());
    send_item(point_at(0, 0, $urandom()));
    drain_all();
    // Oversized rectangle, changed mid-frame: old marks stay in the map.
    set_rect(100, 4095, 50, 4095);
    send_item(point_at(100, 50, $urandom()));
    send_item(point_at(611, 561, $urandom()));
    send_item(point_at(612, 561, $urandom()));
    send_item(point_at(611, 562, $urandom()));
    drain_all();
    // Inverted rectangle keeps nothing.
    set_rect(300, 200, 0, 511);
    send_item(point_at(250, 10, $urandom()));
    send_item(point_at(300, 10, $urandom()));
    drain_all();
    set_rect(4095, 4095, 4095, 4095);
    send_item(point_at(4095, 4095, $urandom()));
    send_item(point_at(4094, 4095, $urandom()));
    drain_all();
    set_rect(0, 4095, 0, 4095);
    send_item(point_at(0, 0, $urandom()));
    send_item(frame_item());
    send_item(point_at(0, 0, $urandom()));
    drain_all();

    send_idle_pct = 33;
    recv_idle_pct = 67;
    random_rect();
    run_phase(PHASE_ITEMS);
    random_rect();
    run_phase(PHASE_ITEMS);

    send_idle_pct = 67;
    recv_idle_pct = 33;
    random_rect();
    run_phase(PHASE_ITEMS);
    random_rect();
    run_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long output hold-off while points keep coming: the block must back up.
    set_rect(0, 511, 0, 511);
    hold_req = ~hold_req;
    run_phase(60);
    random_rect();
    run_phase(PHASE_ITEMS);
    set_rect(0, 511, 0, 511);
    frame_storm();

    repeat (DRAIN_GAP) @(posedge clk);
    $display("Sent %0d items (%0d new frames) across %0d rectangle settings,",
             items_sent, frames_sent, rect_settings);
    $display("checked %0d kept points, incl. a long output hold-off and a frame-count wrap.",
             points_checked);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
